// ----- rtl/rdsw_pkg.sv -----
// rdsw_pkg: shared types, register codes and calendar helpers for the
// rtc date sanitizer. No dependencies.
package rdsw_pkg;

    localparam int unsigned MaxYear  = 99;
    localparam int unsigned MaxMonth = 12;
    localparam int unsigned MaxHour  = 23;
    localparam int unsigned MaxMin   = 59;
    localparam int unsigned PmHour   = 12;

    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 7;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MIN_YEAR  = 2'd0,
        CFG_MIN_MONTH = 2'd1,
        CFG_MIN_DAY   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
    } raw_date_t;

    typedef struct packed {
        logic [6:0] fixed_year;
        logic [3:0] fixed_month;
        logic [4:0] fixed_day;
        logic [4:0] fixed_hours;
        logic [5:0] fixed_minutes;
        logic [5:0] fixed_seconds;
        logic [2:0] weekday;
        logic       pm_flag;
        logic       accepted;
    } fixed_date_t;

    // days in month, zero for month codes outside 1..12; leap when year mod 4 is 0
    function automatic logic [4:0] month_len(input logic [6:0] y, input logic [3:0] m);
        logic leap;
        logic [4:0] len;
        leap = (y[1:0] == 2'b00);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // floor(13 * (fm + 1) / 5) for the shifted month 3..14
    function automatic logic [5:0] month_term(input logic [3:0] fm);
        logic [5:0] t;
        case (fm)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    // x mod 7 by folding: 64 and 8 are both 1 mod 7
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [6:0] a;
        logic [3:0] b;
        logic [3:0] c;
        a = {5'd0, x[7:6]} + {1'b0, x[5:0]};
        b = a[6:3] + {1'b0, a[2:0]};
        c = {3'd0, b[3]} + {1'b0, b[2:0]};
        if (c >= 4'd7)
        begin
            c = c - 4'd7;
        end
        return c[2:0];
    endfunction

    // zeller's congruence for years 2000..2099, 1 monday .. 7 sunday
    function automatic logic [2:0] weekday_of(input logic [6:0] y, input logic [3:0] m,
                                              input logic [4:0] d);
        logic [6:0] yy;
        logic [3:0] fm;
        logic       c19;
        logic [7:0] sum;
        logic [2:0] w;
        c19 = 1'b0;
        if (m < 4'd3)
        begin
            fm = m + 4'd12;
            if (y == 7'd0)
            begin
                yy  = 7'd99;
                c19 = 1'b1;
            end
            else
            begin
                yy = y - 7'd1;
            end
        end
        else
        begin
            fm = m;
            yy = y;
        end
        // century terms leave 0 mod 7 for century 20 and 1 for century 19;
        // the minus one on the day is carried as plus six
        sum = {1'b0, yy} + {3'd0, yy[6:2]} + {2'd0, month_term(fm)} + {3'd0, d}
            + {7'd0, c19} + 8'd6;
        w = mod7(sum);
        return (w == 3'd0) ? 3'd7 : w;
    endfunction

endpackage

// ----- rtl/rtc_date_sanitizer_weekday_top.sv -----
// rtc_date_sanitizer_weekday_top: corrects a raw clock date and time and
// adds weekday, pm flag and accepted flag. Depends on rdsw_pkg.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------
//   raw      | raw_valid / raw_stall    | raw_data   (raw_date_t)
//   fix      | fix_valid / fix_stall    | fix_data   (fixed_date_t)
//   cfg      | cfg_we                   | cfg_index, cfg_data
//
// a raw transaction is taken into the input register, and its result is then
// registered into the result register that drives fix_valid and fix_data.
// one transaction per cycle is sustained while fix_stall is low; the result
// register and the input register form a two-deep pipeline that only holds
// while fix_stall is high. reset clears both valid flags and loads the minimum
// date registers with year 0, month 1, day 1.
module rtc_date_sanitizer_weekday_top
    import rdsw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 raw_valid,
    output logic                 raw_stall,
    input  raw_date_t            raw_data,

    output logic                 fix_valid,
    input  logic                 fix_stall,
    output fixed_date_t          fix_data,

    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    logic [6:0]  min_year_reg;
    logic [3:0]  min_month_reg;
    logic [4:0]  min_day_reg;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    raw_date_t   s1_data_reg;
    logic        fix_valid_reg;
    logic        fix_valid_next;
    fixed_date_t fix_data_reg;
    fixed_date_t fix_data_next;

    logic        s2_ready;
    logic        s1_load;
    logic        s2_load;

    logic        y_bad;
    logic        y_eq;
    logic        m_bad;
    logic [6:0]  y_c;
    logic [3:0]  m_c;
    logic [4:0]  d_c;
    logic [4:0]  lim;
    logic [4:0]  h_c;
    logic [5:0]  mi_c;
    logic [5:0]  s_c;
    logic        ok;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg  <= 7'd0;
            min_month_reg <= 4'd1;
            min_day_reg   <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_YEAR:  min_year_reg  <= cfg_data[6:0];
                CFG_MIN_MONTH: min_month_reg <= cfg_data[3:0];
                CFG_MIN_DAY:   min_day_reg   <= cfg_data[4:0];
                default:       ;
            endcase
        end
    end

    // pipeline flow control
    assign s2_ready       = !fix_valid_reg || !fix_stall;
    assign raw_stall      = s1_valid_reg && !s2_ready;
    assign s1_load        = raw_valid && !raw_stall;
    assign s2_load        = s1_valid_reg && s2_ready;
    assign s1_valid_next  = raw_stall ? s1_valid_reg : raw_valid;
    assign fix_valid_next = s2_ready ? s1_valid_reg : fix_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fix_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fix_valid_reg <= fix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg <= raw_data;
        end
        if (s2_load)
        begin
            fix_data_reg <= fix_data_next;
        end
    end

    // date correction
    always_comb
    begin
        y_bad = (s1_data_reg.year < {1'b0, min_year_reg})
             || (s1_data_reg.year > 8'(MaxYear));
        y_eq  = (s1_data_reg.year == {1'b0, min_year_reg});
        m_bad = (s1_data_reg.month > 8'(MaxMonth));
        y_c   = s1_data_reg.year[6:0];
        m_c   = s1_data_reg.month[3:0];
        d_c   = s1_data_reg.day[4:0];
        lim   = 5'd0;
        if (y_bad)
        begin
            y_c = min_year_reg;
            m_c = min_month_reg;
            d_c = min_day_reg;
        end
        else if (y_eq)
        begin
            if ((s1_data_reg.month < {4'd0, min_month_reg}) || m_bad)
            begin
                m_c = min_month_reg;
                d_c = min_day_reg;
            end
            else
            begin
                lim = month_len(y_c, m_c);
                if (m_c == min_month_reg)
                begin
                    if ((s1_data_reg.day < {3'd0, min_day_reg})
                        || (s1_data_reg.day > {3'd0, lim}))
                    begin
                        d_c = min_day_reg;
                    end
                end
                else if ((s1_data_reg.day == 8'd0) || (s1_data_reg.day > {3'd0, lim}))
                begin
                    d_c = 5'd1;
                end
            end
        end
        else
        begin
            if ((s1_data_reg.month == 8'd0) || m_bad)
            begin
                m_c = 4'd1;
            end
            lim = month_len(y_c, m_c);
            if ((s1_data_reg.day == 8'd0) || (s1_data_reg.day > {3'd0, lim}))
            begin
                d_c = 5'd1;
            end
        end
    end

    // time correction, final range check and result assembly
    always_comb
    begin
        h_c  = (s1_data_reg.hours   > 8'(MaxHour)) ? 5'd0 : s1_data_reg.hours[4:0];
        mi_c = (s1_data_reg.minutes > 8'(MaxMin))  ? 6'd0 : s1_data_reg.minutes[5:0];
        s_c  = (s1_data_reg.seconds > 8'(MaxMin))  ? 6'd0 : s1_data_reg.seconds[5:0];
        // month_len is zero for a month outside 1..12, which fails the day test
        ok   = (y_c <= 7'(MaxYear)) && (d_c != 5'd0) && (d_c <= month_len(y_c, m_c));

        fix_data_next.fixed_year    = y_c;
        fix_data_next.fixed_month   = m_c;
        fix_data_next.fixed_day     = d_c;
        fix_data_next.fixed_hours   = h_c;
        fix_data_next.fixed_minutes = mi_c;
        fix_data_next.fixed_seconds = s_c;
        fix_data_next.weekday       = ok ? weekday_of(y_c, m_c, d_c) : 3'd0;
        fix_data_next.pm_flag       = (h_c > 5'(PmHour));
        fix_data_next.accepted      = ok;
    end

    assign fix_valid = fix_valid_reg;
    assign fix_data  = fix_data_reg;

`ifndef SYNTHESIS
    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid && fix_data.accepted |-> (fix_data.weekday != 3'd0))
        else $error("accepted date without a weekday");

    a_weekday_reject: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid && !fix_data.accepted |-> (fix_data.weekday == 3'd0))
        else $error("rejected date carries a weekday");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid |-> (fix_data.fixed_hours <= 5'(MaxHour))
                   && (fix_data.fixed_minutes <= 6'(MaxMin))
                   && (fix_data.fixed_seconds <= 6'(MaxMin)))
        else $error("corrected time out of range");

    a_pm_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid |-> (fix_data.pm_flag == (fix_data.fixed_hours > 5'(PmHour))))
        else $error("pm flag disagrees with corrected hour");

    a_stall_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        raw_stall |-> s1_valid_reg && fix_valid_reg && fix_stall)
        else $error("input stalled with room in the pipeline");
`endif

endmodule

// ----- verif/tb_rtc_date_sanitizer_weekday_top.sv -----
// tb_rtc_date_sanitizer_weekday_top: self-checking bench for the rtc date sanitizer,
// with a predictor and a result queue in a small scoreboard class, and random gaps
// and stalls on both channels. Depends on rdsw_pkg and rtc_date_sanitizer_weekday_top.
module tb_rtc_date_sanitizer_weekday_top;
    import rdsw_pkg::*;

    class date_fix_board;
        logic [6:0]  lim_year;
        logic [3:0]  lim_month;
        logic [4:0]  lim_day;
        fixed_date_t fix_due[$];
        int          errors;
        int          n_noted;

        function new();
            lim_year  = 7'd0;
            lim_month = 4'd1;
            lim_day   = 5'd1;
            errors    = 0;
            n_noted   = 0;
        endfunction

        function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
            if (m == 0 || m > 12)
            begin
                return 0;
            end
            if (m == 2)
            begin
                return (y % 4 == 0) ? 29 : 28;
            end
            if (m == 4 || m == 6 || m == 9 || m == 11)
            begin
                return 30;
            end
            return 31;
        endfunction

        // zeller for years 2000..2099, 1 monday .. 7 sunday
        function automatic int unsigned day_of_week(input int unsigned y, input int unsigned m,
                                                    input int unsigned d);
            int unsigned fy;
            int unsigned fm;
            int unsigned c;
            int unsigned yy;
            int unsigned w;
            fy = 2000 + y;
            fm = m;
            if (fm < 3)
            begin
                fm = fm + 12;
                fy = fy - 1;
            end
            c  = fy / 100;
            yy = fy % 100;
            w  = (70 + c / 4 + yy + yy / 4 + (13 * (fm + 1)) / 5 + d - 1 - 2 * c) % 7;
            return (w == 0) ? 7 : w;
        endfunction

        function automatic fixed_date_t correct_date(input raw_date_t r);
            int unsigned y;
            int unsigned m;
            int unsigned d;
            int unsigned h;
            int unsigned mi;
            int unsigned s;
            bit          ok;
            fixed_date_t f;
            y  = r.year;
            m  = r.month;
            d  = r.day;
            h  = r.hours;
            mi = r.minutes;
            s  = r.seconds;
            if (y < lim_year || y > 99)
            begin
                y = lim_year;
                m = lim_month;
                d = lim_day;
            end
            else if (y == lim_year)
            begin
                if (m < lim_month || m > 12)
                begin
                    m = lim_month;
                    d = lim_day;
                end
                else if (m == lim_month)
                begin
                    if (d < lim_day || d > days_in(y, m))
                    begin
                        d = lim_day;
                    end
                end
                else if (d < 1 || d > days_in(y, m))
                begin
                    d = 1;
                end
            end
            else
            begin
                if (m < 1 || m > 12)
                begin
                    m = 1;
                end
                if (d < 1 || d > days_in(y, m))
                begin
                    d = 1;
                end
            end
            if (h > 23)
            begin
                h = 0;
            end
            if (mi > 59)
            begin
                mi = 0;
            end
            if (s > 59)
            begin
                s = 0;
            end
            ok = (y <= 99) && (m >= 1) && (m <= 12) && (d >= 1) && (d <= days_in(y, m));
            f.fixed_year    = 7'(y);
            f.fixed_month   = 4'(m);
            f.fixed_day     = 5'(d);
            f.fixed_hours   = 5'(h);
            f.fixed_minutes = 6'(mi);
            f.fixed_seconds = 6'(s);
            f.weekday       = ok ? 3'(day_of_week(y, m, d)) : 3'd0;
            f.pm_flag       = (h > 12);
            f.accepted      = ok;
            return f;
        endfunction

        function void note_raw(input raw_date_t r);
            fix_due.push_back(correct_date(r));
            n_noted++;
        endfunction

        function void compare(input string name, input logic [7:0] want, input logic [7:0] got);
            if (want !== got)
            begin
                errors++;
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void check_fix(input fixed_date_t got);
            fixed_date_t want;
            if (fix_due.size() == 0)
            begin
                errors++;
                $error("result transaction with no raw transaction pending");
                return;
            end
            want = fix_due.pop_front();
            compare("fixed_year", want.fixed_year, got.fixed_year);
            compare("fixed_month", want.fixed_month, got.fixed_month);
            compare("fixed_day", want.fixed_day, got.fixed_day);
            compare("fixed_hours", want.fixed_hours, got.fixed_hours);
            compare("fixed_minutes", want.fixed_minutes, got.fixed_minutes);
            compare("fixed_seconds", want.fixed_seconds, got.fixed_seconds);
            compare("weekday", want.weekday, got.weekday);
            compare("pm_flag", want.pm_flag, got.pm_flag);
            compare("accepted", want.accepted, got.accepted);
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                raw_valid = 1'b0;
    logic                raw_stall;
    raw_date_t           raw_data  = '0;
    logic                fix_valid;
    logic                fix_stall = 1'b0;
    fixed_date_t         fix_data;
    logic                cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = CFG_MIN_YEAR;
    logic [CfgDataW-1:0] cfg_data  = '0;

    date_fix_board sb = new();
    bit            calm = 1'b0;
    int            idle_cycles = 0;

    rtc_date_sanitizer_weekday_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_stall (raw_stall),
        .raw_data  (raw_data),
        .fix_valid (fix_valid),
        .fix_stall (fix_stall),
        .fix_data  (fix_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic raw_date_t raw_at(input int unsigned y, input int unsigned m,
                                         input int unsigned d, input int unsigned h,
                                         input int unsigned mi, input int unsigned s);
        raw_date_t r;
        r.year    = 8'(y);
        r.month   = 8'(m);
        r.day     = 8'(d);
        r.hours   = 8'(h);
        r.minutes = 8'(mi);
        r.seconds = 8'(s);
        return r;
    endfunction

    // mostly plausible dates near the minimum date and month ends, some pure noise
    function automatic raw_date_t rand_date();
        raw_date_t   r;
        int unsigned lo;
        int unsigned pick;
        int unsigned mlen;
        r = raw_at($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
        begin
            return r;
        end
        lo   = (sb.lim_year > 99) ? 0 : sb.lim_year;
        pick = $urandom_range(0, 19);
        if (pick < 5)
        begin
            r.year = 8'(sb.lim_year);
        end
        else if (pick < 17)
        begin
            r.year = 8'($urandom_range(lo, 99));
        end
        else if (pick == 17)
        begin
            r.year = 8'((lo > 0) ? lo - 1 : 100);
        end
        pick = $urandom_range(0, 19);
        if (pick < 3)
        begin
            r.month = 8'(sb.lim_month);
        end
        else if (pick < 17)
        begin
            r.month = 8'($urandom_range(1, 12));
        end
        mlen = sb.days_in(r.year, r.month);
        pick = $urandom_range(0, 19);
        if (pick < 3)
        begin
            r.day = 8'(sb.lim_day);
        end
        else if (pick < 10)
        begin
            r.day = 8'($urandom_range(1, (mlen > 0) ? mlen : 31));
        end
        else if (pick < 15)
        begin
            r.day = 8'(mlen + $urandom_range(0, 1));
        end
        else if (pick < 18)
        begin
            r.day = 8'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 9) < 8)
        begin
            r.hours = 8'($urandom_range(0, 23));
        end
        if ($urandom_range(0, 9) < 8)
        begin
            r.minutes = 8'($urandom_range(0, 59));
        end
        if ($urandom_range(0, 9) < 8)
        begin
            r.seconds = 8'($urandom_range(0, 59));
        end
        return r;
    endfunction

    task automatic send_item(input raw_date_t d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            raw_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        raw_valid <= 1'b1;
        raw_data  <= d;
        @(posedge clk);
        while (raw_stall)
        begin
            @(posedge clk);
        end
        sb.note_raw(d);
    endtask

    task automatic wait_drained();
        raw_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.fix_due.size() != 0);
    endtask

    // writes all three minimum date registers back to back, only while idle
    task automatic set_limits(input int unsigned y, input int unsigned m, input int unsigned d);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_YEAR;
        cfg_data  <= CfgDataW'(y);
        @(posedge clk);
        cfg_index <= CFG_MIN_MONTH;
        cfg_data  <= CfgDataW'(m);
        @(posedge clk);
        cfg_index <= CFG_MIN_DAY;
        cfg_data  <= CfgDataW'(d);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.lim_year  = 7'(y);
        sb.lim_month = 4'(m);
        sb.lim_day   = 5'(d);
    endtask

    // receiver: checks results, random stalls, one long hold-off mid run
    initial
    begin : receiver
        int  stall_left;
        int  hold_left;
        bit  held;
        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (fix_valid && !fix_stall)
            begin
                sb.check_fix(fix_data);
            end
            if (hold_left > 0)
            begin
                fix_stall <= 1'b1;
                hold_left--;
            end
            else if (!held && sb.n_noted >= 300)
            begin
                held      = 1'b1;
                hold_left = 79;
                fix_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                fix_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap();
                fix_stall <= (stall_left > 0);
                if (stall_left > 0)
                begin
                    stall_left--;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (raw_valid && !raw_stall) || (fix_valid && !fix_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= 2000)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int unsigned limits[10][3];
        int          p;
        int          i;
        limits = '{'{0, 1, 1}, '{99, 12, 31}, '{20, 6, 15}, '{127, 15, 31}, '{5, 13, 0},
                   '{0, 0, 0}, '{50, 2, 29}, '{3, 2, 31}, '{0, 0, 0}, '{0, 0, 0}};
        // last two settings are random in range
        for (p = 8; p < 10; p++)
        begin
            limits[p][0] = $urandom_range(0, 99);
            limits[p][1] = $urandom_range(1, 12);
            limits[p][2] = $urandom_range(1, 31);
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // minimum date in mid year: every correction branch
        set_limits(20, 6, 15);
        send_item(raw_at(0, 0, 0, 0, 0, 0));
        send_item(raw_at(255, 255, 255, 255, 255, 255));
        send_item(raw_at(20, 5, 20, 12, 30, 30));
        send_item(raw_at(20, 13, 1, 13, 0, 0));
        send_item(raw_at(20, 6, 14, 1, 1, 1));
        send_item(raw_at(20, 6, 31, 23, 59, 59));
        send_item(raw_at(20, 6, 15, 24, 60, 60));
        send_item(raw_at(20, 7, 0, 11, 10, 10));
        send_item(raw_at(20, 7, 32, 12, 10, 10));
        send_item(raw_at(21, 0, 31, 13, 10, 10));
        send_item(raw_at(24, 2, 29, 6, 6, 6));
        send_item(raw_at(23, 2, 29, 7, 7, 7));
        send_item(raw_at(99, 12, 31, 23, 59, 59));
        send_item(raw_at(100, 3, 3, 3, 3, 3));
        send_item(raw_at(21, 1, 1, 0, 0, 0));
        send_item(raw_at(21, 2, 28, 0, 0, 0));
        wait_drained();

        // default minimum date: year 2000 january and february fall in the prior century
        set_limits(0, 1, 1);
        send_item(raw_at(0, 1, 1, 0, 0, 0));
        send_item(raw_at(0, 2, 29, 12, 0, 0));
        send_item(raw_at(0, 3, 1, 13, 0, 0));
        send_item(raw_at(0, 1, 0, 0, 0, 0));
        send_item(raw_at(1, 1, 1, 0, 0, 0));
        send_item(raw_at(3, 2, 29, 0, 0, 0));
        send_item(raw_at(99, 2, 29, 0, 0, 0));
        wait_drained();

        for (p = 0; p < 10; p++)
        begin
            set_limits(limits[p][0], limits[p][1], limits[p][2]);
            for (i = 0; i < 75; i++)
            begin
                if (i % 25 == 0)
                begin
                    calm = ($urandom_range(0, 3) == 0);
                end
                send_item(rand_date());
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (sb.fix_due.size() != 0)
        begin
            sb.errors++;
            $error("%0d raw transactions never produced a result", sb.fix_due.size());
        end
        if (sb.errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
